// ----- rtl/lect_pkg.sv -----
// Shared types, codes and helpers for the leader election candidate table.
`default_nettype none
package lect_pkg;

	localparam int unsigned ADDR_W = 48;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned LEN_W = 8;
	localparam int unsigned COUNT_OUT_W = 5;
	localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 8'd9;

	// Configuration register indexes (byte address bits [4:3]).
	localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
	localparam logic [1:0] REG_OWN_SCORE = 2'd1;
	localparam logic [1:0] REG_OWN_CHANNEL = 2'd2;

	localparam logic [CHAN_W-1:0] OWN_CHANNEL_RESET = 8'd1;

	typedef enum logic [2:0] {
		STAT_SHORT    = 3'd0,
		STAT_OWN      = 3'd1,
		STAT_KEPT     = 3'd2,
		STAT_RAISED   = 3'd3,
		STAT_INSERTED = 3'd4,
		STAT_FULL     = 3'd5,
		STAT_RESOLVED = 3'd6,
		STAT_CLEARED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [SCORE_W-1:0] score;
		logic [CHAN_W-1:0]  chan;
	} cand_t;

	typedef struct packed {
		status_t status;
		cand_t   winner;
		logic    self_won;
	} res_t;

	localparam int unsigned CAND_W = $bits(cand_t);

	// Higher score wins; equal scores go to the lower address.
	function automatic logic cand_better(input cand_t a, input cand_t b);
		return (a.score > b.score) || ((a.score == b.score) && (a.addr < b.addr));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/leader_election_candidate_table.sv -----
// Top level: configuration registers, candidate memory and sequencer.
//
// Channel   Direction  Transfer
// command   in         start && !busy: mode, sender_address, sender_score,
//                      sender_channel, frame_length
// result    out        done high for one cycle: status, winner_*, self_won, entry_count
// config    in         APB write at psel && penable && pwrite && pready; regs at 8*i
//
// Short, own and clear commands: busy stays low, done follows in the next cycle.
// Frame and resolve commands: busy through one memory read per held entry (through the
// single read port), a final check and a write-back; done follows.
// Reset clears the entry count and the sequencer; memory contents need no clearing.
// The result cannot be stalled; a new command may start while done is high.
`default_nettype none
module leader_election_candidate_table #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [47:0] sender_address,
	input  wire logic [15:0] sender_score,
	input  wire logic [7:0]  sender_channel,
	input  wire logic [7:0]  frame_length,
	output logic             done,
	output logic [2:0]       status,
	output logic [47:0]      winner_address,
	output logic [15:0]      winner_score,
	output logic [7:0]       winner_channel,
	output logic             self_won,
	output logic [4:0]       entry_count
);
	import lect_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [ADDR_W-1:0]  own_address_q;
	logic [SCORE_W-1:0] own_score_q;
	logic [CHAN_W-1:0]  own_channel_q;
	logic               cfg_wr;
	logic [1:0]         cfg_idx;

	cand_t              own;
	cand_t              sender;
	res_t               res;
	logic [CNT_W-1:0]   count;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	cand_t              ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	cand_t              ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			own_score_q <= '0;
			own_channel_q <= OWN_CHANNEL_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OWN_ADDRESS: own_address_q <= pwdata[ADDR_W-1:0];
				REG_OWN_SCORE:   own_score_q <= pwdata[SCORE_W-1:0];
				REG_OWN_CHANNEL: own_channel_q <= pwdata[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_OWN_ADDRESS: prdata = {16'd0, own_address_q};
			REG_OWN_SCORE:   prdata = {48'd0, own_score_q};
			REG_OWN_CHANNEL: prdata = {56'd0, own_channel_q};
			default:         prdata = '0;
		endcase
	end

	assign own = '{addr: own_address_q, score: own_score_q, chan: own_channel_q};
	assign sender = '{addr: sender_address, score: sender_score, chan: sender_channel};

	lect_ram #(
		.WIDTH(CAND_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lect_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.sender      (sender),
		.frame_length(frame_length),
		.own         (own),
		.busy        (busy),
		.done        (done),
		.res         (res),
		.count       (count),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// Report the low bits of the count, zero-extended for small tables.
	assign count_ext = {{COUNT_OUT_W{1'b0}}, count};
	assign entry_count = count_ext[COUNT_OUT_W-1:0];

	assign status = res.status;
	assign winner_address = res.winner.addr;
	assign winner_score = res.winner.score;
	assign winner_channel = res.winner.chan;
	assign self_won = res.self_won;

endmodule
`default_nettype wire

// ----- rtl/lect_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lect_ram #(
	parameter int unsigned WIDTH = 72,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lect_ctrl.sv -----
// Sequencer: scans the candidate memory, updates at most one entry and, on resolve, selects the winner.
`default_nettype none
module lect_ctrl #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [1:0]                           mode,
	input  wire lect_pkg::cand_t                      sender,
	input  wire logic [lect_pkg::LEN_W-1:0]           frame_length,
	input  wire lect_pkg::cand_t                      own,
	output logic                                      busy,
	output logic                                      done,
	output lect_pkg::res_t                            res,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]          count,
	output logic                                      ram_we,
	output logic [$clog2(MAX_ENTRIES)-1:0]            ram_waddr,
	output lect_pkg::cand_t                           ram_wdata,
	output logic                                      ram_re,
	output logic [$clog2(MAX_ENTRIES)-1:0]            ram_raddr,
	input  wire lect_pkg::cand_t                      ram_rdata
);
	import lect_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	state_t            state_q, state_d;
	cand_t             key_q;
	logic              resolve_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              chk_valid_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic              found_q;
	logic              raise_q;
	logic [IDX_W-1:0]  found_idx_q;
	logic              best_v_q;
	cand_t             best_q;
	res_t              res_q;
	logic              done_q;

	logic              accept;
	logic              go_scan;
	logic              issue;
	logic              hit;
	logic              hit_raise;
	cand_t             eff;
	logic              take;
	logic              room;
	logic              append;
	cand_t             final_best;
	status_t           quick_status;
	status_t           finish_status;

	always_comb begin
		accept = start && (state_q == ST_IDLE);
		go_scan = !mode[1] && (mode[0] ||
			((frame_length >= MIN_FRAME_BYTES) && (sender.addr != own.addr)));
		issue = (state_q == ST_SCAN) && (rd_idx_q < count_q);
		hit = chk_valid_q && (ram_rdata.addr == key_q.addr);
		hit_raise = key_q.score > ram_rdata.score;
		// An entry raised by this offer competes with its new values.
		eff = (hit && hit_raise) ? key_q : ram_rdata;
		take = chk_valid_q && (!best_v_q || cand_better(eff, best_q));
		room = count_q < MAX_CNT;
		append = !found_q && room;
		final_best = (append && (!best_v_q || cand_better(key_q, best_q))) ? key_q : best_q;

		if (mode[1]) begin
			quick_status = STAT_CLEARED;
		end else if (frame_length < MIN_FRAME_BYTES) begin
			quick_status = STAT_SHORT;
		end else begin
			quick_status = STAT_OWN;
		end

		if (resolve_q) begin
			finish_status = STAT_RESOLVED;
		end else if (found_q) begin
			finish_status = raise_q ? STAT_RAISED : STAT_KEPT;
		end else if (room) begin
			finish_status = STAT_INSERTED;
		end else begin
			finish_status = STAT_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_re = issue;
		ram_raddr = rd_idx_q[IDX_W-1:0];
		ram_we = 1'b0;
		ram_waddr = found_q ? found_idx_q : count_q[IDX_W-1:0];
		ram_wdata = key_q;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// The last entry is checked in the cycle that issues no read.
				if (!issue) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				ram_we = (found_q && raise_q) || append;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_idx_q <= '0;
			chk_valid_q <= 1'b0;
			found_q <= 1'b0;
			best_v_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						chk_valid_q <= 1'b0;
						found_q <= 1'b0;
						best_v_q <= 1'b0;
						if (mode[1]) begin
							count_q <= '0;
						end
						if (!go_scan) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					chk_valid_q <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (take) begin
						best_v_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					done_q <= 1'b1;
					if (append) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= mode[0] ? own : sender;
					resolve_q <= mode[0];
					res_q.status <= quick_status;
					res_q.winner <= '0;
					res_q.self_won <= 1'b0;
				end
			end
			ST_SCAN: begin
				chk_idx_q <= rd_idx_q[IDX_W-1:0];
				if (hit) begin
					found_idx_q <= chk_idx_q;
					raise_q <= hit_raise;
				end
				if (take) begin
					best_q <= eff;
				end
			end
			ST_FINISH: begin
				res_q.status <= finish_status;
				res_q.winner <= resolve_q ? final_best : '0;
				res_q.self_won <= resolve_q && (final_best.addr == own.addr);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res = res_q;
	assign count = count_q;

endmodule
`default_nettype wire
